[rtl/rmth_pkg.sv]
package rmth_pkg;

	localparam int unsigned HALF_CAPACITY_DEF = 512;
	localparam int unsigned SAMPLE_BITS_DEF   = 25;
	localparam int unsigned COUNT_BITS        = 11;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	// Heap selector for the datapath.
	typedef enum logic [0:0] {
		HEAP_LOWER = 1'b0,
		HEAP_UPPER = 1'b1
	} heap_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic      load;       // capture the input transaction
		logic      clear;      // empty both heaps, or flag overflow for an insert
		logic      push_init;  // start a sift-up into the chosen heap
		logic      push_rd;    // read the parent of the hole
		logic      push_step;  // compare the parent, move it down or finish
		logic      swap_init;  // capture both tops
		logic      rep_init;   // start a sift-down in the chosen heap
		logic      rep_rd;     // read the children of the hole
		logic      rep_rd2;    // second child read
		logic      rep_step;   // compare the children, move one up or finish
		heap_sel_t heap;
	} rmth_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic      full;       // both heaps at capacity
		logic      to_upper;   // sizes differ, insert goes to upper heap
		logic      push_done;  // sift-up finished (hole at root or parent not below)
		logic      need_swap;  // both heaps non-empty and upper top below lower top
		logic      rep_leaf;   // hole has no child: sift-down finished
		logic      rep_done;   // sift-down finished at this step
	} rmth_sts_t;

endpackage

[rtl/rmth_datapath.sv]
module rmth_datapath
	import rmth_pkg::*;
#(
	parameter int unsigned HALF_CAPACITY = HALF_CAPACITY_DEF,
	parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmth_cmd_t              cmd,
	output rmth_sts_t              sts,
	input  logic                   in_opcode,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output logic [SAMPLE_BITS-1:0] median,
	output logic [COUNT_BITS-1:0]  count,
	output logic                   overflow
);

	localparam int unsigned AW = (HALF_CAPACITY > 1) ? $clog2(HALF_CAPACITY) : 1;
	localparam int unsigned SW = $clog2(HALF_CAPACITY + 1);
	localparam int unsigned PW = AW + 2;

	logic [SAMPLE_BITS-1:0] lo_mem [HALF_CAPACITY];
	logic [SAMPLE_BITS-1:0] up_mem [HALF_CAPACITY];

	logic [SW-1:0]          lo_size_q, up_size_q;
	logic                   op_q;
	logic [SAMPLE_BITS-1:0] val_q;      // value being placed
	logic [SAMPLE_BITS-1:0] other_q;    // second top kept for the upper sift-down
	logic [SAMPLE_BITS-1:0] lo_top_q;   // cached root of the lower heap
	logic [SAMPLE_BITS-1:0] up_top_q;   // cached root of the upper heap
	logic [PW-1:0]          pos_q;
	logic [SAMPLE_BITS-1:0] rd_lo_q, rd_up_q;
	logic [SAMPLE_BITS-1:0] left_q;
	logic                   ovf_q;

	logic [SW-1:0]          size_sel;
	logic [PW-1:0]          parent, left, right;
	logic                   is_max;
	logic [SAMPLE_BITS-1:0] rd_sel;
	logic                   has_left, has_right;
	logic                   pick_right;
	logic [SAMPLE_BITS-1:0] best_v;
	logic [PW-1:0]          best_p;
	logic                   best_above;
	logic                   parent_below;
	logic                   rep_leaf;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic [AW-1:0]          rd_addr;

	assign is_max   = (cmd.heap == HEAP_LOWER);
	assign size_sel = is_max ? lo_size_q : up_size_q;
	assign parent   = (pos_q - PW'(1)) >> 1;
	assign left     = {pos_q[PW-2:0], 1'b1};
	assign right    = left + PW'(1);
	assign rd_sel   = is_max ? rd_lo_q : rd_up_q;
	assign has_left  = (PW'(size_sel) > left);
	assign has_right = (PW'(size_sel) > right);
	// root has no child: the new top is placed at once
	assign rep_leaf  = (size_sel < SW'(2));

	// rd_sel holds the right child during rep_step, left_q the left one
	assign pick_right = has_right &&
		(is_max ? (rd_sel > left_q) : (rd_sel < left_q));
	assign best_v     = pick_right ? rd_sel : left_q;
	assign best_p     = pick_right ? right : left;
	assign best_above = is_max ? (best_v > val_q) : (best_v < val_q);
	assign parent_below = is_max ? (val_q > rd_sel) : (val_q < rd_sel);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = val_q;
		rd_addr = parent[AW-1:0];
		if (cmd.rep_rd) begin
			rd_addr = left[AW-1:0];
		end else if (cmd.rep_rd2) begin
			rd_addr = right[AW-1:0];
		end
		if (cmd.push_step) begin
			wr_en = 1'b1;
			if (pos_q != '0 && parent_below) begin
				wr_data = rd_sel;
			end
		end else if (cmd.rep_step) begin
			wr_en = 1'b1;
			if (has_left && best_above) begin
				wr_data = best_v;
			end
		end else if (cmd.rep_init && rep_leaf) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = is_max ? val_q : other_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && is_max) begin
			lo_mem[wr_addr] <= wr_data;
		end
		if (wr_en && !is_max) begin
			up_mem[wr_addr] <= wr_data;
		end
		rd_lo_q <= lo_mem[rd_addr];
		rd_up_q <= up_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_size_q <= '0;
			up_size_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				ovf_q <= 1'b0;
			end
			if (cmd.clear) begin
				if (op_q == OP_CLEAR) begin
					lo_size_q <= '0;
					up_size_q <= '0;
				end
				ovf_q <= (op_q == OP_INSERT);
			end
			if (cmd.push_init) begin
				if (is_max) begin
					lo_size_q <= lo_size_q + SW'(1);
				end else begin
					up_size_q <= up_size_q + SW'(1);
				end
			end
		end
	end

	// clear with op_q == insert is the overflow path: sizes stay
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_opcode;
			val_q <= in_sample;
		end
		if (cmd.push_init) begin
			pos_q <= PW'(size_sel);
		end
		if (cmd.rep_rd) begin
			pos_q <= pos_q;
		end
		if (cmd.push_step) begin
			if (pos_q != '0 && parent_below) begin
				pos_q <= parent;
			end
			if (pos_q == '0 || !parent_below) begin
				if (pos_q == '0) begin
					if (is_max) lo_top_q <= val_q;
					else up_top_q <= val_q;
				end
			end
		end
		if (cmd.swap_init) begin
			val_q   <= up_top_q;
			other_q <= lo_top_q;
		end
		if (cmd.rep_init) begin
			pos_q <= '0;
			if (!is_max) begin
				val_q <= other_q;
			end
			if (rep_leaf) begin
				if (is_max) lo_top_q <= val_q;
				else up_top_q <= other_q;
			end
		end
		if (cmd.rep_rd2) begin
			left_q <= rd_sel;
		end
		if (cmd.rep_step) begin
			if (has_left && best_above) begin
				if (pos_q == '0) begin
					if (is_max) lo_top_q <= best_v;
					else up_top_q <= best_v;
				end
				pos_q <= best_p;
			end else if (pos_q == '0) begin
				if (is_max) lo_top_q <= val_q;
				else up_top_q <= val_q;
			end
		end
	end

	always_comb begin
		sts.full      = (lo_size_q == SW'(HALF_CAPACITY)) && (up_size_q == SW'(HALF_CAPACITY));
		sts.to_upper  = (lo_size_q != up_size_q);
		sts.push_done = (pos_q == '0) || !parent_below;
		sts.need_swap = (lo_size_q != '0) && (up_size_q != '0) && (up_top_q < lo_top_q);
		sts.rep_leaf  = rep_leaf;
		sts.rep_done  = !(has_left && best_above);
	end

	assign median   = (lo_size_q != '0) ? lo_top_q : '0;
	assign count    = COUNT_BITS'({1'b0, lo_size_q} + {1'b0, up_size_q});
	assign overflow = ovf_q;

endmodule

[rtl/rmth_ctrl.sv]
module rmth_ctrl
	import rmth_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  opcode_t   in_opcode,
	output logic      out_valid,
	input  logic      out_ready,
	output rmth_cmd_t cmd,
	input  rmth_sts_t sts
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_DECODE  = 11'b00000000010,
		S_PRD     = 11'b00000000100,
		S_PSTEP   = 11'b00000001000,
		S_CHECK   = 11'b00000010000,
		S_RINIT   = 11'b00000100000,
		S_RRD     = 11'b00001000000,
		S_RRD2    = 11'b00010000000,
		S_RWAIT   = 11'b00100000000,
		S_RSTEP   = 11'b01000000000,
		S_OUT     = 11'b10000000000
	} state_t;

	state_t    state_q, state_d;
	heap_sel_t heap_q, heap_d;
	logic      op_clear_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d    = state_q;
		heap_d     = heap_q;
		cmd        = '0;
		cmd.heap   = heap_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (op_clear_q || sts.full) begin
					cmd.clear = 1'b1;
					state_d   = S_OUT;
				end else begin
					heap_d        = sts.to_upper ? HEAP_UPPER : HEAP_LOWER;
					cmd.heap      = heap_d;
					cmd.push_init = 1'b1;
					state_d       = S_PRD;
				end
			end
			S_PRD: begin
				cmd.push_rd = 1'b1;
				state_d     = S_PSTEP;
			end
			S_PSTEP: begin
				cmd.push_step = 1'b1;
				state_d       = sts.push_done ? S_CHECK : S_PRD;
			end
			S_CHECK: begin
				if (sts.need_swap) begin
					cmd.swap_init = 1'b1;
					heap_d        = HEAP_LOWER;
					state_d       = S_RINIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RINIT: begin
				cmd.rep_init = 1'b1;
				state_d      = sts.rep_leaf ? S_RWAIT : S_RRD;
			end
			S_RRD: begin
				cmd.rep_rd = 1'b1;
				state_d    = S_RRD2;
			end
			S_RRD2: begin
				cmd.rep_rd2 = 1'b1;
				state_d     = S_RSTEP;
			end
			S_RSTEP: begin
				cmd.rep_step = 1'b1;
				state_d      = sts.rep_done ? S_RWAIT : S_RRD;
			end
			S_RWAIT: begin
				if (heap_q == HEAP_LOWER) begin
					heap_d  = HEAP_UPPER;
					state_d = S_RINIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			heap_q     <= HEAP_LOWER;
			op_clear_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			heap_q     <= heap_d;
			if (cmd.load) begin
				op_clear_q <= (in_opcode == OP_CLEAR);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_ready) |=> (state_q == S_OUT))
		else $error("result dropped before accept");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE))
		else $error("load not followed by decode");

endmodule

[rtl/running_median_two_heaps_unit.sv]
// Running median over a stream of unsigned samples, kept in two heaps held in
// on-chip memories: a max-heap with the lower half and a min-heap with the
// upper half, HALF_CAPACITY entries each. Every transaction (insert or clear)
// returns one result: the lower median, the number of samples held, and an
// overflow flag for an insert into a full store (which then changes nothing).
// One transaction is worked on at a time. A clear or a dropped insert goes from
// decode straight to the output; an insert climbs its heap one level per parent
// read and step, and when the tops must be exchanged, both heaps are sifted down
// one level per pair of child reads (made one after the other, as each heap memory
// has a single read port) and a step. The heap tops are cached in registers
// so the median is shown at once. No clearing pass is needed after reset.
module running_median_two_heaps_unit
	import rmth_pkg::*;
#(
	parameter int unsigned HALF_CAPACITY = HALF_CAPACITY_DEF,
	parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] median,
	output logic [COUNT_BITS-1:0]  count,
	output logic                   overflow
);

	rmth_cmd_t cmd;
	rmth_sts_t sts;

	// sequence the sift steps
	rmth_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (opcode_t'(opcode)),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// hold heap memories, sizes and cached tops
	rmth_datapath #(
		.HALF_CAPACITY (HALF_CAPACITY),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_opcode (opcode),
		.in_sample (sample),
		.median    (median),
		.count     (count),
		.overflow  (overflow)
	);

endmodule

[tb/sv/running_median_two_heaps_unit_tb.sv]
`timescale 1ns / 1ps

module running_median_two_heaps_unit_tb;
	import rmth_pkg::*;

	localparam int unsigned HALF_CAP = HALF_CAPACITY_DEF;
	localparam int unsigned SBITS    = SAMPLE_BITS_DEF;

	typedef logic [SBITS-1:0]      sample_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		sample_t median;
		count_t  count;
		logic    overflow;
	} median_result_t;

	// Scoreboard: holds its own copy of both heaps and a queue of pending results.
	class median_scoreboard;
		sample_t        lo_heap[HALF_CAP];
		sample_t        hi_heap[HALF_CAP];
		int unsigned    lo_size;
		int unsigned    hi_size;
		median_result_t pending[$];
		int unsigned    errors;

		function new();
			lo_size = 0;
			hi_size = 0;
			errors = 0;
		endfunction

		// Is a above b in this heap's ordering
		function bit ranks_over(bit is_max, sample_t a, sample_t b);
			return is_max ? (a > b) : (a < b);
		endfunction

		function void sift_up(bit is_max, sample_t v);
			int unsigned pos;
			int unsigned parent;
			if (is_max) pos = lo_size; else pos = hi_size;
			if (is_max) lo_size++; else hi_size++;
			while (pos > 0) begin
				parent = (pos - 1) / 2;
				if (is_max) begin
					if (!ranks_over(1, v, lo_heap[parent])) break;
					lo_heap[pos] = lo_heap[parent];
				end else begin
					if (!ranks_over(0, v, hi_heap[parent])) break;
					hi_heap[pos] = hi_heap[parent];
				end
				pos = parent;
			end
			if (is_max) lo_heap[pos] = v; else hi_heap[pos] = v;
		endfunction

		function void sift_down(bit is_max, sample_t v);
			int unsigned pos;
			int unsigned lc;
			int unsigned best;
			int unsigned sz;
			sample_t     h[HALF_CAP];
			pos = 0;
			if (is_max) begin sz = lo_size; h = lo_heap; end
			else begin sz = hi_size; h = hi_heap; end
			forever begin
				lc = 2 * pos + 1;
				if (lc >= sz) break;
				best = lc;
				if (lc + 1 < sz && ranks_over(is_max, h[lc + 1], h[lc])) best = lc + 1;
				if (!ranks_over(is_max, h[best], v)) break;
				h[pos] = h[best];
				pos = best;
			end
			h[pos] = v;
			if (is_max) lo_heap = h; else hi_heap = h;
		endfunction

		// Note an accepted input transaction and queue its expected result.
		function void note_input(opcode_t op, sample_t s);
			median_result_t r;
			sample_t        lt;
			sample_t        ut;
			r.overflow = 1'b0;
			if (op == OP_CLEAR) begin
				lo_size = 0;
				hi_size = 0;
			end else if (lo_size >= HALF_CAP && hi_size >= HALF_CAP) begin
				r.overflow = 1'b1;
			end else begin
				sift_up(lo_size != hi_size ? 1'b0 : 1'b1, s);
				if (lo_size > 0 && hi_size > 0 && hi_heap[0] < lo_heap[0]) begin
					lt = lo_heap[0];
					ut = hi_heap[0];
					sift_down(1, ut);
					sift_down(0, lt);
				end
			end
			r.median = (lo_size > 0) ? lo_heap[0] : '0;
			r.count = count_t'(lo_size + hi_size);
			pending.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(sample_t m, count_t c, logic ov);
			median_result_t e;
			if (pending.size() == 0) begin
				report("result with nothing pending", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (m !== e.median) report("median", m, e.median);
			if (c !== e.count) report("count", c, e.count);
			if (ov !== e.overflow) report("overflow", ov, e.overflow);
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	logic    opcode;
	sample_t sample;
	logic    out_valid;
	logic    out_ready;
	sample_t median;
	count_t  count;
	logic    overflow;

	median_scoreboard sb;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	sample_t          pool[$];

	running_median_two_heaps_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.count     (count),
		.overflow  (overflow)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: stall at random, check every accepted result transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(median, count, overflow);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Drive one transaction: optional idle gap, then hold valid until accepted.
	task automatic send_item(opcode_t op, sample_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			// drop valid and scramble the payload while idle
			in_valid <= 1'b0;
			opcode <= 1'($urandom_range(1));
			sample <= sample_t'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(op, s);
	endtask

	task automatic send_insert(sample_t s);
		send_item(OP_INSERT, s);
	endtask

	// Pick a sample: duplicates from a pool, extremes, narrow and full ranges.
	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(9))
			0: s = '0;
			1: s = '1;
			2, 3: s = pool.size() ? pool[$urandom_range(pool.size() - 1)] : sample_t'($urandom);
			4: s = sample_t'($urandom_range(15));
			default: s = sample_t'($urandom);
		endcase
		if (pool.size() < 64) pool.push_back(s);
		return s;
	endfunction

	task automatic random_phase(int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(199) == 0) send_item(OP_CLEAR, sample_t'($urandom));
			else send_insert(pick_sample());
		end
	endtask

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned i;
		sb = new();
		send_idle_pct = 33;
		recv_idle_pct = 62;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		sample = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, extremes, ties, clear on empty and non-empty store.
		send_item(OP_CLEAR, '1);
		send_insert('1);
		send_insert('0);
		send_insert('1);
		send_insert(sample_t'(1) << (SBITS - 1));
		send_insert(sample_t'(5));
		send_insert(sample_t'(5));
		send_insert(sample_t'({SBITS/2{2'b01}}));
		send_insert(sample_t'({SBITS/2{2'b10}}));
		send_item(OP_CLEAR, '0);
		send_item(OP_CLEAR, '1);
		send_insert(sample_t'(7));

		// Fill the store, then drive inserts into the full store.
		send_idle_pct = 5;
		recv_idle_pct = 5;
		for (i = 1; i < 2 * HALF_CAP; i++) send_insert(sample_t'($urandom));
		send_insert('1);
		send_insert('0);
		send_insert(sample_t'($urandom));
		send_item(OP_CLEAR, '0);

		send_idle_pct = 33;
		recv_idle_pct = 62;
		random_phase(105);
		send_idle_pct = 62;
		recv_idle_pct = 33;
		random_phase(105);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(105);
		in_valid <= 1'b0;

		i = 0;
		while (sb.pending.size() != 0 && i < 100000) begin
			@(posedge clk);
			i++;
		end
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/rmth_pkg.sv
rtl/rmth_datapath.sv
rtl/rmth_ctrl.sv
rtl/running_median_two_heaps_unit.sv
tb/sv/running_median_two_heaps_unit_tb.sv
